>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Holds the operation and status codes, the cell command codes and the
// packed payload structs of the input and result channels.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Default sizes of the entry chain.
	localparam int CAPACITY_DEF     = 16;
	localparam int HANDLE_WIDTH_DEF = 16;

	// Fixed field widths of the channel payloads.
	localparam int FIELD_HANDLE_W = 16;
	localparam int FIELD_LEVEL_W  = 2;
	localparam int FIELD_COUNT_W  = 5;

	// Operation codes carried by an input transfer.
	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	// Status codes reported with every result transfer.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_PUSH = 2'd1,
		CELL_POP  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic [FIELD_LEVEL_W-1:0] level;
	} cell_cmd_t;

	typedef struct packed {
		func_t                     func;
		logic [FIELD_LEVEL_W-1:0]  level;
		logic [FIELD_HANDLE_W-1:0] handle;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_HANDLE_W-1:0] head_handle;
		logic [FIELD_LEVEL_W-1:0]  head_level;
		logic                      is_empty;
		logic [FIELD_COUNT_W-1:0]  entry_count;
		status_t                   status;
	} out_item_t;

endpackage

>>> design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry chain
// Holds one entry and, on each command, keeps it, takes the new entry,
// takes its left neighbor's entry (push) or its right neighbor's (pop).
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int HW = spq_pkg::HANDLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  spq_pkg::cell_cmd_t                 cmd,
	input  logic [HW-1:0]                      new_handle,
	input  logic                               occupied,
	input  logic                               left_after,
	input  logic [spq_pkg::FIELD_LEVEL_W-1:0]  left_level,
	input  logic [HW-1:0]                      left_handle,
	input  logic [spq_pkg::FIELD_LEVEL_W-1:0]  right_level,
	input  logic [HW-1:0]                      right_handle,
	output logic                               after,
	output logic [spq_pkg::FIELD_LEVEL_W-1:0]  level_q,
	output logic [HW-1:0]                      handle_q
);
	import spq_pkg::*;

	// A new entry goes behind this one when it is stored and no less urgent.
	assign after = occupied && (level_q <= cmd.level);

	// Entry update: insert, shift right, shift left or hold.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_PUSH: begin
				if (!after) begin
					if (left_after) begin
						level_q  <= cmd.level;
						handle_q <= new_handle;
					end else begin
						level_q  <= left_level;
						handle_q <= left_handle;
					end
				end
			end
			CELL_POP: begin
				level_q  <= right_level;
				handle_q <= right_handle;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded four-level priority queue of handles
// A row of entry cells kept sorted by level, first in first out within a
// level; push, pop, clear and query operations with a head report.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one operation
//   per transfer: push, pop head, clear all or query. The result channel
//   (out_valid, out_ready, out_data) returns exactly one result per
//   operation: the head handle and level, an empty flag, the entry count
//   and a status code.
//   Every cell compares the pushed level with its own entry in parallel and
//   shifts toward its neighbor in the same cycle, so the result of an
//   operation is valid on the clock after the input transfer, and a
//   new operation can be taken every cycle while results are drained.
//   When the receiver stalls, the pending result holds and in_ready drops
//   until it is taken; the queue state does not change meanwhile.
//   Reset empties the queue at once; no clearing pass is needed, since
//   entries beyond the count are never reported.
//   A pop on an empty queue and a push into a full queue change nothing and
//   are flagged in the status field.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
	parameter int CAPACITY     = spq_pkg::CAPACITY_DEF,
	parameter int HANDLE_WIDTH = spq_pkg::HANDLE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output spq_pkg::out_item_t out_data
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (HANDLE_WIDTH < FIELD_HANDLE_W) ? HANDLE_WIDTH : FIELD_HANDLE_W;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	status_t                  status_q;
	status_t                  status_d;
	logic                     out_valid_q;
	cell_cmd_t                cmd;
	logic [HANDLE_WIDTH-1:0]  new_handle;

	logic [CAPACITY-1:0]      occ;
	logic [CAPACITY-1:0]      after;
	logic [FIELD_LEVEL_W-1:0] level_q  [CAPACITY];
	logic [HANDLE_WIDTH-1:0]  handle_q [CAPACITY];

	// Handshake: the state only moves when the result slot is free.
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign full       = (count_q == CW'(CAPACITY));
	assign empty      = (count_q == '0);
	assign new_handle = HANDLE_WIDTH'(in_data.handle[SW-1:0]);

	// Operation decode: cell command, next count and status.
	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.level = in_data.level;
		count_d   = count_q;
		status_d  = ST_OK;
		if (accept) begin
			case (in_data.func)
				FUNC_PUSH: begin
					if (full) begin
						status_d = ST_PUSH_FULL;
					end else begin
						cmd.op  = CELL_PUSH;
						count_d = count_q + CW'(1);
					end
				end
				FUNC_POP: begin
					if (empty) begin
						status_d = ST_POP_EMPTY;
					end else begin
						cmd.op  = CELL_POP;
						count_d = count_q - CW'(1);
					end
				end
				FUNC_CLEAR: begin
					count_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers: fill count, status and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_d;
				status_q <= status_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Chain of entry cells, each linked to its two neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     l_after;
		logic [FIELD_LEVEL_W-1:0] l_level;
		logic [HANDLE_WIDTH-1:0]  l_handle;
		logic [FIELD_LEVEL_W-1:0] r_level;
		logic [HANDLE_WIDTH-1:0]  r_handle;

		assign occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign l_after  = 1'b1;
			assign l_level  = level_q[i];
			assign l_handle = handle_q[i];
		end else begin : g_inner_l
			assign l_after  = after[i-1];
			assign l_level  = level_q[i-1];
			assign l_handle = handle_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_level  = level_q[i];
			assign r_handle = handle_q[i];
		end else begin : g_inner_r
			assign r_level  = level_q[i+1];
			assign r_handle = handle_q[i+1];
		end

		spq_cell #(
			.HW(HANDLE_WIDTH)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.new_handle  (new_handle),
			.occupied    (occ[i]),
			.left_after  (l_after),
			.left_level  (l_level),
			.left_handle (l_handle),
			.right_level (r_level),
			.right_handle(r_handle),
			.after       (after[i]),
			.level_q     (level_q[i]),
			.handle_q    (handle_q[i])
		);
	end

	// Result fields come straight from the state, which holds while stalled.
	always_comb begin
		out_data.entry_count = FIELD_COUNT_W'(count_q);
		out_data.status      = status_q;
		out_data.is_empty    = empty;
		if (empty) begin
			out_data.head_handle = '0;
			out_data.head_level  = '0;
		end else begin
			out_data.head_handle = FIELD_HANDLE_W'(handle_q[0][SW-1:0]);
			out_data.head_level  = level_q[0];
		end
	end

endmodule

>>> tb/spq_order_checker.sv
// ----------------------------------------------------------------------------
// spq_order_checker: result checker for the stable priority queue
// Watches both channels, keeps its own copy of the sorted entry row, predicts
// the report of every accepted operation and compares each result transfer
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module spq_order_checker
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending
);

	localparam int DEPTH = CAPACITY_DEF;
	localparam int SHOWN_LIMIT = 10;

	// Shadow copy of the entry row, head at index 0.
	logic [FIELD_LEVEL_W-1:0]  slot_level [DEPTH];
	logic [FIELD_HANDLE_W-1:0] slot_handle [DEPTH];
	int                        slot_fill = 0;

	// Predicted reports waiting for their result transfer, oldest first.
	out_item_t expected_reports [$];
	out_item_t oldest_report;

	initial fail_count = 0;

	// Count a failure and show the first few of them.
	task automatic flag_failure(input string what);
		fail_count++;
		if (fail_count <= SHOWN_LIMIT)
			$display("check failed at %0t: %s", $time, what);
	endtask

	// Apply one operation to the shadow row and return the report it yields.
	function automatic out_item_t apply_operation(input in_item_t op);
		out_item_t rep;
		int        pos;
		int        k;
		bit        found;
		rep.status = ST_OK;
		case (op.func)
			FUNC_PUSH: begin
				if (slot_fill >= DEPTH) begin
					rep.status = ST_PUSH_FULL;
				end else begin
					// New entry goes ahead of the first strictly less urgent one.
					pos = slot_fill;
					found = 1'b0;
					for (k = 0; k < slot_fill; k++) begin
						if (!found && op.level < slot_level[k]) begin
							pos = k;
							found = 1'b1;
						end
					end
					for (k = slot_fill; k > pos; k--) begin
						slot_level[k] = slot_level[k-1];
						slot_handle[k] = slot_handle[k-1];
					end
					slot_level[pos] = op.level;
					slot_handle[pos] = op.handle;
					slot_fill++;
				end
			end
			FUNC_POP: begin
				if (slot_fill == 0) begin
					rep.status = ST_POP_EMPTY;
				end else begin
					for (k = 0; k + 1 < slot_fill; k++) begin
						slot_level[k] = slot_level[k+1];
						slot_handle[k] = slot_handle[k+1];
					end
					slot_fill--;
				end
			end
			FUNC_CLEAR: begin
				slot_fill = 0;
			end
			default: begin
			end
		endcase
		if (slot_fill == 0) begin
			rep.head_handle = '0;
			rep.head_level = '0;
			rep.is_empty = 1'b1;
		end else begin
			rep.head_handle = slot_handle[0];
			rep.head_level = slot_level[0];
			rep.is_empty = 1'b0;
		end
		rep.entry_count = FIELD_COUNT_W'(slot_fill);
		return rep;
	endfunction

	// Compare results first, then record the prediction for a new operation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_fill = 0;
			expected_reports.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					flag_failure($sformatf("result transfer with nothing expected: %p",
						out_data));
				end else begin
					oldest_report = expected_reports.pop_front();
					if (out_data.head_handle !== oldest_report.head_handle ||
					    out_data.head_level !== oldest_report.head_level ||
					    out_data.is_empty !== oldest_report.is_empty ||
					    out_data.entry_count !== oldest_report.entry_count ||
					    out_data.status !== oldest_report.status)
						flag_failure($sformatf("expected %p, got %p",
							oldest_report, out_data));
				end
			end
			if (in_valid && in_ready)
				expected_reports.push_back(apply_operation(in_data));
			pending <= expected_reports.size();
		end
	end

endmodule

>>> tb/stable_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: top level testbench for the priority queue
// Drives a directed opening and several random phases of push, pop, clear
// and query operations, with random idling on both channels except in the
// last phase, and leaves the checking to the order checker beside the block.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
	import spq_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_OPS   = 400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int fail_count;
	int pending;
	bit steady = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	stable_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	spq_order_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver side: random stall bursts, none in the final phase.
	always @(negedge clk) begin
		if (steady) begin
			out_ready = 1'b1;
		end else if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			out_ready = 1'b0;
			hold_left = $urandom_range(1, 7) - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	// Watchdog: give up when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offer one operation, called at a falling edge, returns at a falling edge.
	task automatic send_op(input func_t f, input logic [1:0] lv, input logic [15:0] h);
		int gap;
		if (!steady && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = '{func: f, level: lv, handle: h};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Hold the sender off until every predicted result has been taken.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Random operations with the given mix in percent; the rest are queries.
	task automatic run_phase(input int n_ops, input int push_pct, input int pop_pct,
		input int clear_pct);
		int          pick;
		func_t       f;
		logic [15:0] h;
		for (int i = 0; i < n_ops; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				f = FUNC_PUSH;
			else if (pick < push_pct + pop_pct)
				f = FUNC_POP;
			else if (pick < push_pct + pop_pct + clear_pct)
				f = FUNC_CLEAR;
			else
				f = FUNC_QUERY;
			case ($urandom_range(0, 15))
				0: h = '0;
				1: h = '1;
				default: h = 16'($urandom);
			endcase
			send_op(f, 2'($urandom_range(0, 3)), h);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening: empty-queue cases, then ordering within and across levels.
		send_op(FUNC_QUERY, 2'd3, 16'hFFFF);
		send_op(FUNC_POP, 2'd2, 16'h1234);
		send_op(FUNC_CLEAR, 2'd1, 16'hABCD);
		send_op(FUNC_PUSH, 2'd3, 16'hFFFF);
		send_op(FUNC_PUSH, 2'd3, 16'h0001);
		send_op(FUNC_PUSH, 2'd0, 16'h0000);
		send_op(FUNC_PUSH, 2'd1, 16'h8000);
		send_op(FUNC_PUSH, 2'd0, 16'h7FFF);
		send_op(FUNC_PUSH, 2'd2, 16'h5A5A);
		send_op(FUNC_QUERY, 2'd0, 16'h0000);
		send_op(FUNC_POP, 2'd3, 16'hFFFF);
		send_op(FUNC_POP, 2'd0, 16'h0000);
		send_op(FUNC_POP, 2'd1, 16'hA5A5);
		send_op(FUNC_CLEAR, 2'd3, 16'hFFFF);
		send_op(FUNC_POP, 2'd0, 16'h0000);
		wait_drained();

		// Fill-heavy mix keeps the queue full and drops pushes.
		run_phase(PHASE_OPS, 70, 20, 2);
		wait_drained();
		run_phase(PHASE_OPS, 40, 40, 3);
		wait_drained();
		// Drain-heavy mix hits pops on an empty queue.
		run_phase(PHASE_OPS, 25, 65, 2);
		wait_drained();
		// Back-to-back traffic with no idling on either side.
		steady = 1'b1;
		run_phase(PHASE_OPS, 50, 45, 2);

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
